>>> hw/rtl/qpht_pkg.sv
// Shared types and codes for the quadratic probe hash table.
`timescale 1ns / 1ps

package qpht_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_MISSING = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [30:0] key;
        logic [31:0] record;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot_index;
        logic [31:0] record_out;
    } t_rsp;

endpackage

>>> hw/rtl/quadratic_probe_hash_table_top.sv
// Quadratic probing hash table with one key and record memory.
//
// Channel   Direction  Handshake            Payload
// request   in         start high, busy low qpht_pkg::t_req  (command, key, record)
// response  out        strobe, one cycle    qpht_pkg::t_rsp  (status, slot_index, record_out)
//
// After reset the block clears the table memory, one slot a cycle, with busy high. An
// operation is accepted, its key is reduced to its home slot (reciprocal multiply,
// multiply back, subtract and correct) and it is then probed with one read a cycle from
// the memory read port until the response strobe.
// Busy falls in the cycle the response is shown, so the next request may be transferred
// then. The unused command code answers in the next cycle. The receiver cannot stall.
`timescale 1ns / 1ps

module quadratic_probe_hash_table_top #(
    parameter int TABLE_SIZE = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  qpht_pkg::t_req i_req,
    output logic           busy,
    output logic           strobe,
    output qpht_pkg::t_rsp o_rsp
);

    import qpht_pkg::*;

    localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CW = $clog2(TABLE_SIZE + 1);
    localparam logic [IW:0]   TS       = (IW + 1)'(TABLE_SIZE);
    localparam logic [IW-1:0] LAST     = IW'(TABLE_SIZE - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(TABLE_SIZE);
    localparam logic [CW-1:0] CNT_LAST = CW'(TABLE_SIZE - 1);
    localparam logic [31:0]   RECIP    = 32'((64'd1 << (31 + IW)) / 64'(TABLE_SIZE));

    typedef struct packed {
        logic        valid;
        logic [30:0] key;
        logic [31:0] record;
    } t_entry;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_PROBE
    } t_state;

    t_entry mem [TABLE_SIZE];

    t_state        r_state;
    t_req          r_req;
    logic [IW-1:0] r_slot;
    logic [IW-1:0] r_step;
    logic [CW-1:0] r_issued;
    logic [62:0]   r_prod;
    logic [30:0]   r_qn;
    logic [1:0]    r_mcnt;
    t_entry        r_rd;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_addr;
    logic          r_rd_first;
    logic          r_rd_last;
    logic          r_strobe;
    t_rsp          r_rsp;

    logic [30:0]   n_qn;
    logic [IW-1:0] n_mod;
    logic [IW-1:0] n_slot;
    logic [IW-1:0] n_step;
    logic          w_hit;
    logic          w_done;
    logic [1:0]    w_status;
    logic          w_we;
    logic [IW-1:0] w_waddr;
    t_entry        w_wdata;

    // The reciprocal gives a quotient that is exact or one short, so the key minus the
    // quotient times TABLE_SIZE lies below twice TABLE_SIZE and one subtraction finishes it.
    always_comb begin
        logic [30:0] quot;
        logic [30:0] diff;
        logic [IW:0] rem;
        quot  = 31'(r_prod >> (31 + IW));
        n_qn  = quot * 31'(TABLE_SIZE);
        diff  = r_req.key - r_qn;
        rem   = diff[IW:0];
        if (rem >= TS) begin
            rem = rem - TS;
        end
        n_mod = rem[IW-1:0];
    end

    // The next probe slot adds the odd step 2i+1, both kept below TABLE_SIZE.
    always_comb begin
        logic [IW:0] s;
        logic [IW:0] d;
        s = {1'b0, r_slot} + {1'b0, r_step};
        if (s >= TS) begin
            s = s - TS;
        end
        d = {1'b0, r_step} + (IW + 1)'(2);
        if (d >= TS) begin
            d = d - TS;
        end
        n_slot = s[IW-1:0];
        n_step = d[IW-1:0];
    end

    always_comb begin
        logic miss_home;
        if (r_req.command == CMD_INSERT) begin
            w_hit     = !r_rd.valid;
            miss_home = 1'b0;
        end else begin
            w_hit     = r_rd.valid && (r_rd.key == r_req.key);
            miss_home = r_rd_first && !r_rd.valid;
        end
        w_done = r_rd_vld && (w_hit || miss_home || r_rd_last);
        if (w_hit) begin
            w_status = STAT_OK;
        end else if (r_req.command == CMD_INSERT) begin
            w_status = STAT_FULL;
        end else begin
            w_status = STAT_MISSING;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_rd_addr;
        w_wdata = '0;
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_slot;
        end else if (r_state == S_PROBE && r_rd_vld && w_hit) begin
            if (r_req.command == CMD_INSERT) begin
                w_we    = 1'b1;
                w_wdata = '{valid: 1'b1, key: r_req.key, record: r_req.record};
            end else if (r_req.command == CMD_DELETE) begin
                w_we    = 1'b1;
                w_wdata = '{valid: 1'b0, key: r_rd.key, record: r_rd.record};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd <= mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_slot   <= '0;
            r_strobe <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_slot <= r_slot + IW'(1);
                    if (r_slot == LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_req <= i_req;
                        if (i_req.command == CMD_INSERT || i_req.command == CMD_DELETE
                                || i_req.command == CMD_SEARCH) begin
                            r_state <= S_MOD;
                            r_mcnt  <= '0;
                        end else begin
                            r_strobe <= 1'b1;
                            r_rsp    <= '{status: STAT_MISSING, slot_index: 4'd0,
                                          record_out: 32'd0};
                        end
                    end
                end
                S_MOD: begin
                    r_mcnt <= r_mcnt + 2'd1;
                    if (r_mcnt == 2'd0) begin
                        r_prod <= {32'd0, r_req.key} * {31'd0, RECIP};
                    end
                    if (r_mcnt == 2'd1) begin
                        r_qn <= n_qn;
                    end
                    if (r_mcnt == 2'd2) begin
                        r_slot   <= n_mod;
                        r_state  <= S_PROBE;
                        r_step   <= IW'(1);
                        r_issued <= '0;
                        r_rd_vld <= 1'b0;
                    end
                end
                S_PROBE: begin
                    if (r_issued != CNT_FULL) begin
                        r_rd_vld   <= 1'b1;
                        r_rd_addr  <= r_slot;
                        r_rd_first <= (r_issued == '0);
                        r_rd_last  <= (r_issued == CNT_LAST);
                        r_slot     <= n_slot;
                        r_step     <= n_step;
                        r_issued   <= r_issued + CW'(1);
                    end else begin
                        r_rd_vld <= 1'b0;
                    end
                    if (w_done) begin
                        r_state  <= S_IDLE;
                        r_rd_vld <= 1'b0;
                        r_strobe <= 1'b1;
                        r_rsp.status <= w_status;
                        r_rsp.slot_index <= w_hit ? 4'(r_rd_addr) : 4'd0;
                        r_rsp.record_out <= (w_hit && r_req.command != CMD_INSERT)
                                            ? r_rd.record : 32'd0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign strobe = r_strobe;
    assign o_rsp  = r_rsp;

endmodule
